FILE: design/lmxy_pkg.sv
// Shared types, sizes and codes for the LED matrix coordinate to strip index block.
// No dependencies; imported by lmxy_fold and the top level.
package lmxy_pkg;

    // Matrix and coordinate limits
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int COORD_BITS = 16;

    // Fixed field widths
    localparam int CFG_DATA_BITS = 7;
    localparam int INDEX_BITS    = 12;
    localparam int POS_BITS      = 6;

    // Internal widths derived from the limits
    localparam int MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SIZE_BITS = $clog2(MAX_DIM + 1);
    localparam int IDX_BITS  = 2 * SIZE_BITS;

    // Divider pipeline: magnitude bits retired STEP_BITS per stage
    localparam int MAG_BITS  = COORD_BITS - 1;
    localparam int STEP_BITS = 3;
    localparam int DIV_STG   = (MAG_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DVD_BITS  = DIV_STG * STEP_BITS;

    // Stage numbering: 0 capture, 1..DIV_STG divide, fold, orient, output
    localparam int FOLD_STG   = DIV_STG + 1;
    localparam int ORIENT_STG = DIV_STG + 2;
    localparam int OUT_STG    = DIV_STG + 3;
    localparam int NUM_STG    = OUT_STG + 1;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_CORNER = 2'd2,
        CFG_ORDER  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CORNER_BL = 2'd0,
        CORNER_BR = 2'd1,
        CORNER_TL = 2'd2,
        CORNER_TR = 2'd3
    } t_corner;

    typedef enum logic [1:0] {
        ORDER_ROW_ZIGZAG = 2'd0,
        ORDER_ROW_SERP   = 2'd1,
        ORDER_COL_ZIGZAG = 2'd2,
        ORDER_COL_SERP   = 2'd3
    } t_order;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
        logic                         x_reflect;
        logic                         y_reflect;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_BITS-1:0] led_index;
        logic [POS_BITS-1:0]   folded_col;
        logic [POS_BITS-1:0]   folded_row;
    } t_out_item;

endpackage

FILE: design/led_matrix_coordinate_to_strip_index_top.sv
// Top level of the LED matrix coordinate to strip index block.
// Depends on lmxy_pkg and instantiates lmxy_fold once per axis.
//
// Usage:
//   Input channel (i_valid / o_stall / i_item) carries a signed x, y pair and a
//   wrap-or-mirror choice per axis. A transfer happens on a rising edge with
//   i_valid high and o_stall low.
//   Output channel (o_valid / i_stall / o_item) gives the strip index and the
//   folded column and row; a transfer happens with o_valid high and i_stall low.
//   Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data)
//   writes width, height, origin corner and strip order; it is always ready.
//   Write it only while no item is in flight.
// Depth: capture, divide, fold, orient and output stages; the floor-modulo
//   divider, three quotient bits per stage, sets the depth.
// Throughput: one item per clock, sustained while i_stall stays low.
// Reset: empties the pipeline and loads 16 x 16, bottom-left, rows zigzag.
// Stall: each stage holds while the stage after it is full and held, so
//   bubbles are squeezed out and o_stall rises only once every stage is full.
module led_matrix_coordinate_to_strip_index_top (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  lmxy_pkg::t_in_item                       i_item,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output lmxy_pkg::t_out_item                      o_item,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  lmxy_pkg::t_cfg_idx                       i_cfg_index,
    input  logic [lmxy_pkg::CFG_DATA_BITS-1:0]       i_cfg_data
);
    import lmxy_pkg::*;

    // Configuration registers
    logic [CFG_DATA_BITS-1:0] r_matrix_width;
    logic [CFG_DATA_BITS-1:0] r_matrix_height;
    t_corner                  r_origin_corner;
    t_order                   r_strip_order;

    // Effective sizes after clamping to 1..MAX
    logic [SIZE_BITS-1:0] size_w;
    logic [SIZE_BITS-1:0] size_h;

    // Pipeline control: one valid bit per stage, one load enable per stage
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] stg_en;

    logic [SIZE_BITS-1:0] fold_col;
    logic [SIZE_BITS-1:0] fold_row;

    // Orient stage registers
    logic [SIZE_BITS-1:0] r_line;
    logic [SIZE_BITS-1:0] r_pos;
    logic [SIZE_BITS-1:0] r_or_col;
    logic [SIZE_BITS-1:0] r_or_row;
    logic [SIZE_BITS-1:0] n_line;
    logic [SIZE_BITS-1:0] n_pos;

    // Output stage registers
    logic [IDX_BITS-1:0]  r_index;
    logic [SIZE_BITS-1:0] r_out_col;
    logic [SIZE_BITS-1:0] r_out_row;
    logic [IDX_BITS-1:0]  n_index;

    logic by_cols;

    // Configuration writes: always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_width  <= CFG_DATA_BITS'(16);
            r_matrix_height <= CFG_DATA_BITS'(16);
            r_origin_corner <= CORNER_BL;
            r_strip_order   <= ORDER_ROW_ZIGZAG;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_matrix_width  <= i_cfg_data;
                CFG_HEIGHT: r_matrix_height <= i_cfg_data;
                CFG_CORNER: r_origin_corner <= t_corner'(i_cfg_data[1:0]);
                CFG_ORDER:  r_strip_order   <= t_order'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // Treat a zero size as one, and cap at the matrix limit
    always_comb begin
        if (r_matrix_width == '0) begin
            size_w = SIZE_BITS'(1);
        end else if (int'(r_matrix_width) > MAX_WIDTH) begin
            size_w = SIZE_BITS'(MAX_WIDTH);
        end else begin
            size_w = SIZE_BITS'(r_matrix_width);
        end
        if (r_matrix_height == '0) begin
            size_h = SIZE_BITS'(1);
        end else if (int'(r_matrix_height) > MAX_HEIGHT) begin
            size_h = SIZE_BITS'(MAX_HEIGHT);
        end else begin
            size_h = SIZE_BITS'(r_matrix_height);
        end
    end

    // Advance a stage when it is empty or its contents move on
    always_comb begin
        stg_en[OUT_STG] = !r_vld[OUT_STG] || !i_stall;
        for (int k = OUT_STG - 1; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign o_stall = !stg_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Fold each axis into the matrix
    lmxy_fold u_fold_x (
        .i_clk     (i_clk),
        .i_en      (stg_en[FOLD_STG:0]),
        .i_coord   (i_item.x_coord),
        .i_reflect (i_item.x_reflect),
        .i_size    (size_w),
        .o_fold    (fold_col)
    );

    lmxy_fold u_fold_y (
        .i_clk     (i_clk),
        .i_en      (stg_en[FOLD_STG:0]),
        .i_coord   (i_item.y_coord),
        .i_reflect (i_item.y_reflect),
        .i_size    (size_h),
        .o_fold    (fold_row)
    );

    assign by_cols = (r_strip_order == ORDER_COL_ZIGZAG) || (r_strip_order == ORDER_COL_SERP);

    // Distances from the origin corner, then run back every second line if serpentine
    always_comb begin
        logic [SIZE_BITS-1:0] cx;
        logic [SIZE_BITS-1:0] ry;
        logic                 right;
        logic                 top;
        logic                 snake;
        right = (r_origin_corner == CORNER_BR) || (r_origin_corner == CORNER_TR);
        top   = (r_origin_corner == CORNER_TL) || (r_origin_corner == CORNER_TR);
        snake = (r_strip_order == ORDER_ROW_SERP) || (r_strip_order == ORDER_COL_SERP);
        cx    = right ? (size_w - SIZE_BITS'(1) - fold_col) : fold_col;
        ry    = top   ? (size_h - SIZE_BITS'(1) - fold_row) : fold_row;
        if (by_cols) begin
            n_line = cx;
            n_pos  = (snake && cx[0]) ? (size_h - SIZE_BITS'(1) - ry) : ry;
        end else begin
            n_line = ry;
            n_pos  = (snake && ry[0]) ? (size_w - SIZE_BITS'(1) - cx) : cx;
        end
    end

    // Line number times line length, plus position in the line
    assign n_index = IDX_BITS'(r_line) * IDX_BITS'(by_cols ? size_h : size_w)
                   + IDX_BITS'(r_pos);

    always_ff @(posedge i_clk) begin
        if (stg_en[ORIENT_STG]) begin
            r_line   <= n_line;
            r_pos    <= n_pos;
            r_or_col <= fold_col;
            r_or_row <= fold_row;
        end
        if (stg_en[OUT_STG]) begin
            r_index   <= n_index;
            r_out_col <= r_or_col;
            r_out_row <= r_or_row;
        end
    end

    assign o_valid           = r_vld[OUT_STG];
    assign o_item.led_index  = INDEX_BITS'(r_index);
    assign o_item.folded_col = POS_BITS'(r_out_col);
    assign o_item.folded_row = POS_BITS'(r_out_row);

endmodule

FILE: design/lmxy_fold.sv
// One axis fold: pipelined floor modulo by the matrix size, with optional mirroring.
// Depends on lmxy_pkg; stage loads are driven by the top-level handshake chain.
module lmxy_fold (
    input  logic                                 i_clk,
    input  logic [lmxy_pkg::FOLD_STG:0]          i_en,
    input  logic signed [lmxy_pkg::COORD_BITS-1:0] i_coord,
    input  logic                                 i_reflect,
    input  logic [lmxy_pkg::SIZE_BITS-1:0]       i_size,
    output logic [lmxy_pkg::SIZE_BITS-1:0]       o_fold
);
    import lmxy_pkg::*;

    logic [SIZE_BITS-1:0] r_rem  [0:DIV_STG];
    logic [DVD_BITS-1:0]  r_dvd  [0:DIV_STG];
    logic                 r_neg  [0:DIV_STG];
    logic                 r_refl [0:DIV_STG];
    logic                 r_qlsb [0:DIV_STG];
    logic [SIZE_BITS-1:0] n_rem  [1:DIV_STG];
    logic [DVD_BITS-1:0]  n_dvd  [1:DIV_STG];
    logic                 n_qlsb [1:DIV_STG];
    logic [SIZE_BITS-1:0] r_fold;
    logic [SIZE_BITS-1:0] n_fold;
    logic [MAG_BITS-1:0]  mag;

    // Negative c folds as ~c: floor(c/s) = -(q'+1), c mod s = s-1-r'
    assign mag = i_coord[COORD_BITS-1] ? ~i_coord[MAG_BITS-1:0] : i_coord[MAG_BITS-1:0];

    // Restoring division, STEP_BITS quotient bits per stage; keep only the last one
    always_comb begin
        logic [SIZE_BITS-1:0] rem;
        logic [SIZE_BITS:0]   sh;
        logic [DVD_BITS-1:0]  dvd;
        logic                 q;
        for (int k = 1; k <= DIV_STG; k++) begin
            rem = r_rem[k-1];
            dvd = r_dvd[k-1];
            q   = r_qlsb[k-1];
            for (int j = 0; j < STEP_BITS; j++) begin
                sh  = {rem, dvd[DVD_BITS-1]};
                dvd = {dvd[DVD_BITS-2:0], 1'b0};
                if (sh >= {1'b0, i_size}) begin
                    rem = SIZE_BITS'(sh - {1'b0, i_size});
                    q   = 1'b1;
                end else begin
                    rem = SIZE_BITS'(sh);
                    q   = 1'b0;
                end
            end
            n_rem[k]  = rem;
            n_dvd[k]  = dvd;
            n_qlsb[k] = q;
        end
    end

    // Mirror when exactly one of: negative input, reflect on an odd floor tile
    always_comb begin
        logic odd;
        odd = r_neg[DIV_STG] ^ r_qlsb[DIV_STG];
        if (r_neg[DIV_STG] ^ (r_refl[DIV_STG] & odd)) begin
            n_fold = i_size - SIZE_BITS'(1) - r_rem[DIV_STG];
        end else begin
            n_fold = r_rem[DIV_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0]  <= '0;
            r_dvd[0]  <= DVD_BITS'(mag);
            r_neg[0]  <= i_coord[COORD_BITS-1];
            r_refl[0] <= i_reflect;
            r_qlsb[0] <= 1'b0;
        end
        for (int k = 1; k <= DIV_STG; k++) begin
            if (i_en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_dvd[k]  <= n_dvd[k];
                r_neg[k]  <= r_neg[k-1];
                r_refl[k] <= r_refl[k-1];
                r_qlsb[k] <= n_qlsb[k];
            end
        end
        if (i_en[FOLD_STG]) begin
            r_fold <= n_fold;
        end
    end

    assign o_fold = r_fold;

endmodule
